>>> rtl/core/hvt_pkg.sv
// hvt_pkg: shared constants, types and helpers of the time-to-collision core
// no dependencies; used by every module under rtl/core
package hvt_pkg;

	localparam int CORDIC_STAGES = 32;
	localparam int ATAN_ENTRIES  = 40;
	localparam int CW            = 36;
	localparam int ISQ_STAGES    = 32;
	localparam int ISQ_W         = 64;
	localparam int DIV_BITS      = 40;

	// stage at which the divider input sits, and the stage of its result
	localparam int DIV_IN_STAGE  = 3 + (CORDIC_STAGES + 1) + 3 + ISQ_STAGES + CORDIC_STAGES + 2;
	localparam int DIV_OUT_STAGE = DIV_IN_STAGE + DIV_BITS;
	localparam int OUT_LAT       = DIV_OUT_STAGE + 1;

	typedef logic signed [CW-1:0] cval_t;

	localparam cval_t Q30_ONE     = 36'sd1073741824;
	localparam cval_t Q30_PI      = 36'sd3373259426;
	localparam cval_t Q30_HALF_PI = 36'sd1686629713;
	localparam cval_t CORDIC_GAIN = 36'sd652032874;

	localparam logic [31:0]        DEG7_TO_RAD31 = 32'd4024455254;
	localparam logic signed [33:0] FULL_TURN     = 34'sd3600000000;
	localparam logic signed [33:0] HALF_TURN     = 34'sd1800000000;

	localparam logic [14:0] HEADING_NONE = 15'd28800;
	localparam logic [14:0] HEADING_Q1   = 15'd7200;
	localparam logic [14:0] HEADING_Q2   = 15'd14400;
	localparam logic [14:0] HEADING_Q3   = 15'd21600;

	localparam logic [31:0] SENT_FAR   = 32'd2560512;
	localparam logic [31:0] SENT_SLOW  = 32'd2560000;
	localparam logic [13:0] DIST_SCALE = 14'd12800;

	localparam logic [22:0] RADIUS_RESET = 23'd6371000;
	localparam logic        REG_RADIUS   = 1'b0;

	localparam cval_t ATAN_TAB [ATAN_ENTRIES] = '{
		36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
		36'sd67021687, 36'sd33543516, 36'sd16775851, 36'sd8388437,
		36'sd4194283, 36'sd2097149, 36'sd1048576, 36'sd524288,
		36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
		36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048,
		36'sd1024, 36'sd512, 36'sd256, 36'sd128,
		36'sd64, 36'sd32, 36'sd16, 36'sd8,
		36'sd4, 36'sd2, 36'sd1, 36'sd0,
		36'sd0, 36'sd0, 36'sd0, 36'sd0,
		36'sd0, 36'sd0, 36'sd0, 36'sd0
	};

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_QUAD   = 2'd1,
		ST_FASTER = 2'd2,
		ST_EQUAL  = 2'd3
	} status_t;

	typedef struct packed {
		logic        calc;
		logic        hav;
		status_t     st;
		logic [12:0] dspeed;
	} meta_t;

	// 1e-7 degree to Q2.30 radians, truncated toward zero
	function automatic logic signed [34:0] to_rad(input logic signed [33:0] u);
		logic [32:0] mag;
		logic [64:0] prod;
		logic [33:0] r;
		mag  = u[33] ? (~u[32:0] + 33'd1) : u[32:0];
		prod = 65'(mag) * 65'(DEG7_TO_RAD31);
		r    = prod[64:31];
		return u[33] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

endpackage

>>> rtl/core/hvt_cordic_rot.sv
// hvt_cordic_rot: pipelined CORDIC rotation giving sine and cosine of a Q2.30 angle
// depends on hvt_pkg
module hvt_cordic_rot (
	input  logic                  clk,
	input  logic signed [34:0]    angle,
	output hvt_pkg::cval_t        sine,
	output hvt_pkg::cval_t        cosine
);
	localparam int N = hvt_pkg::CORDIC_STAGES;

	hvt_pkg::cval_t th;
	hvt_pkg::cval_t zf;
	logic           nf;
	hvt_pkg::cval_t zf_s;
	logic           nf_s;

	hvt_pkg::cval_t x_s   [N];
	hvt_pkg::cval_t y_s   [N];
	hvt_pkg::cval_t z_s   [N];
	logic           neg_s [N];

	// fold into [-pi/2, pi/2]
	always_comb begin
		th = hvt_pkg::cval_t'(angle);
		zf = th;
		nf = 1'b0;
		if (th > hvt_pkg::Q30_HALF_PI) begin
			zf = hvt_pkg::Q30_PI - th;
			nf = 1'b1;
		end else if (th < -hvt_pkg::Q30_HALF_PI) begin
			zf = -hvt_pkg::Q30_PI - th;
			nf = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		zf_s <= zf;
		nf_s <= nf;
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		hvt_pkg::cval_t xi;
		hvt_pkg::cval_t yi;
		hvt_pkg::cval_t zi;
		logic           ni;
		if (i == 0) begin : g_first
			assign xi = hvt_pkg::CORDIC_GAIN;
			assign yi = '0;
			assign zi = zf_s;
			assign ni = nf_s;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ni = neg_s[i-1];
		end
		if (i < hvt_pkg::ATAN_ENTRIES) begin : g_rot
			always_ff @(posedge clk) begin
				if (!zi[hvt_pkg::CW-1]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - hvt_pkg::ATAN_TAB[i];
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + hvt_pkg::ATAN_TAB[i];
				end
				neg_s[i] <= ni;
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				x_s[i]   <= xi;
				y_s[i]   <= yi;
				z_s[i]   <= zi;
				neg_s[i] <= ni;
			end
		end
	end

	assign sine   = y_s[N-1];
	assign cosine = neg_s[N-1] ? -x_s[N-1] : x_s[N-1];

endmodule

>>> rtl/core/hvt_isqrt.sv
// hvt_isqrt: pipelined integer square root, one result bit from two bits of the radicand a stage
// depends on hvt_pkg
module hvt_isqrt (
	input  logic        clk,
	input  logic [60:0] rad,
	output logic [30:0] root
);
	localparam int N = hvt_pkg::ISQ_STAGES;
	localparam int W = hvt_pkg::ISQ_W;

	logic [W-1:0] rem_s [N];
	logic [W-1:0] res_s [N];

	for (genvar i = 0; i < N; i++) begin : g_st
		localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1) - 2 * i);
		logic [W-1:0] ri;
		logic [W-1:0] qi;
		logic [W-1:0] trial;
		if (i == 0) begin : g_first
			assign ri = W'(rad);
			assign qi = '0;
		end else begin : g_next
			assign ri = rem_s[i-1];
			assign qi = res_s[i-1];
		end
		assign trial = qi + BIT;
		always_ff @(posedge clk) begin
			if (ri >= trial) begin
				rem_s[i] <= ri - trial;
				res_s[i] <= (qi >> 1) + BIT;
			end else begin
				rem_s[i] <= ri;
				res_s[i] <= qi >> 1;
			end
		end
	end

	assign root = res_s[N-1][30:0];

endmodule

>>> rtl/core/hvt_cordic_vec.sv
// hvt_cordic_vec: pipelined CORDIC vectoring giving the angle of a vector in Q2.30
// depends on hvt_pkg
module hvt_cordic_vec (
	input  logic           clk,
	input  logic [30:0]    xin,
	input  logic [30:0]    yin,
	output hvt_pkg::cval_t angle
);
	localparam int N = hvt_pkg::CORDIC_STAGES;

	hvt_pkg::cval_t x_s [N];
	hvt_pkg::cval_t y_s [N];
	hvt_pkg::cval_t z_s [N];

	for (genvar i = 0; i < N; i++) begin : g_st
		hvt_pkg::cval_t xi;
		hvt_pkg::cval_t yi;
		hvt_pkg::cval_t zi;
		if (i == 0) begin : g_first
			assign xi = $signed({5'd0, xin});
			assign yi = $signed({5'd0, yin});
			assign zi = '0;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
		end
		if (i < hvt_pkg::ATAN_ENTRIES) begin : g_rot
			always_ff @(posedge clk) begin
				if (!yi[hvt_pkg::CW-1]) begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + hvt_pkg::ATAN_TAB[i];
				end else begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - hvt_pkg::ATAN_TAB[i];
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				x_s[i] <= xi;
				y_s[i] <= yi;
				z_s[i] <= zi;
			end
		end
	end

	assign angle = z_s[N-1];

endmodule

>>> rtl/core/hvt_div.sv
// hvt_div: pipelined restoring divider, one quotient bit a stage
// depends on hvt_pkg
module hvt_div (
	input  logic                         clk,
	input  logic [hvt_pkg::DIV_BITS-1:0] num,
	input  logic [12:0]                  den,
	output logic [hvt_pkg::DIV_BITS-1:0] quo
);
	localparam int N = hvt_pkg::DIV_BITS;

	logic [N-1:0] n_s [N];
	logic [12:0]  d_s [N];
	logic [12:0]  r_s [N];
	logic [N-1:0] q_s [N];

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [N-1:0] ni;
		logic [12:0]  di;
		logic [12:0]  ri;
		logic [N-1:0] qi;
		logic [13:0]  t;
		logic         ge;
		if (i == 0) begin : g_first
			assign ni = num;
			assign di = den;
			assign ri = '0;
			assign qi = '0;
		end else begin : g_next
			assign ni = n_s[i-1];
			assign di = d_s[i-1];
			assign ri = r_s[i-1];
			assign qi = q_s[i-1];
		end
		assign t  = {ri, ni[N-1-i]};
		assign ge = t >= {1'b0, di};
		always_ff @(posedge clk) begin
			n_s[i] <= ni;
			d_s[i] <= di;
			r_s[i] <= ge ? 13'(t - {1'b0, di}) : t[12:0];
			q_s[i] <= {qi[N-2:0], ge};
		end
	end

	assign quo = q_s[N-1];

endmodule

>>> rtl/core/haversine_time_to_collision_core.sv
// haversine_time_to_collision_core: top level of the time-to-collision pipeline
// depends on hvt_pkg, hvt_cordic_rot, hvt_isqrt, hvt_cordic_vec, hvt_div
//
// channel   handshake                        carries
// config    psel/penable/pwrite, pready = 1  earth_radius_m at byte address 0
// input     start && !busy                   host and remote positions, speeds, heading
// result    done, one cycle                  ttc_q8, status
//
// one transaction accepted every cycle, busy is never raised
// the path holds a CORDIC rotation chain and a vectoring
// chain in series, a 32-stage square root and a 40-stage divider, one stage per bit or step
// reset clears only the valid line, the done register and the radius register
// results cannot be held off, so the pipeline never stalls
module haversine_time_to_collision_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic signed [30:0] host_lat,
	input  logic signed [31:0] host_lon,
	input  logic [12:0]        host_speed,
	input  logic [14:0]        host_heading,
	input  logic signed [30:0] remote_lat,
	input  logic signed [31:0] remote_lon,
	input  logic [12:0]        remote_speed,
	output logic               done,
	output logic [31:0]        ttc_q8,
	output logic [1:0]         status
);
	localparam int MD = hvt_pkg::DIV_OUT_STAGE;

	logic [22:0] radius_q;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == hvt_pkg::REG_RADIUS) ? {9'd0, radius_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hvt_pkg::RADIUS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == hvt_pkg::REG_RADIUS) begin
			radius_q <= pwdata[22:0];
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// classification
	logic signed [31:0] dlat;
	logic signed [32:0] dlon;
	logic               match;
	hvt_pkg::meta_t     meta_in;

	always_comb begin
		dlat  = {remote_lat[30], remote_lat} - {host_lat[30], host_lat};
		dlon  = {remote_lon[31], remote_lon} - {host_lon[31], host_lon};
		match = 1'b0;
		if (host_heading <= hvt_pkg::HEADING_Q1) begin
			match = !dlat[31] && !dlon[32];
		end else if (host_heading <= hvt_pkg::HEADING_Q2) begin
			match = (dlat[31] || dlat == 32'sd0) && !dlon[32];
		end else if (host_heading <= hvt_pkg::HEADING_Q3) begin
			match = (dlat[31] || dlat == 32'sd0) && (dlon[32] || dlon == 33'sd0);
		end else if (host_heading <= hvt_pkg::HEADING_NONE) begin
			match = !dlat[31] && (dlon[32] || dlon == 33'sd0);
		end
		meta_in.hav    = host_heading != hvt_pkg::HEADING_NONE;
		meta_in.dspeed = host_speed - remote_speed;
		meta_in.calc   = 1'b0;
		meta_in.st     = hvt_pkg::ST_OK;
		if (meta_in.hav && !match) begin
			meta_in.st = hvt_pkg::ST_QUAD;
		end else if (host_speed < remote_speed) begin
			meta_in.st = hvt_pkg::ST_FASTER;
		end else if (host_speed == remote_speed) begin
			meta_in.st = hvt_pkg::ST_EQUAL;
		end else begin
			meta_in.calc = 1'b1;
		end
	end

	// valid and side information line
	logic           vld_q  [MD];
	hvt_pkg::meta_t meta_q [MD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MD; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= accept;
			for (int i = 1; i < MD; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		meta_q[0] <= meta_in;
		for (int i = 1; i < MD; i++) begin
			meta_q[i] <= meta_q[i-1];
		end
	end

	// stage 1: differences
	logic signed [30:0] hlat_s1, rlat_s1;
	logic signed [31:0] dlat_s1;
	logic signed [32:0] dlon_s1;

	always_ff @(posedge clk) begin
		hlat_s1 <= host_lat;
		rlat_s1 <= remote_lat;
		dlat_s1 <= {host_lat[30], host_lat} - {remote_lat[30], remote_lat};
		dlon_s1 <= {host_lon[31], host_lon} - {remote_lon[31], remote_lon};
	end

	// stage 2: longitude wrap
	logic signed [33:0] lonv;
	logic signed [33:0] lonw;
	logic signed [30:0] hlat_s2, rlat_s2;
	logic signed [31:0] dlat_s2;
	logic signed [31:0] lonw_s2;

	always_comb begin
		lonv = 34'(dlon_s1);
		if (lonv >= hvt_pkg::HALF_TURN) begin
			lonw = lonv - hvt_pkg::FULL_TURN;
		end else if (lonv < -hvt_pkg::HALF_TURN) begin
			lonw = lonv + hvt_pkg::FULL_TURN;
		end else begin
			lonw = lonv;
		end
	end

	always_ff @(posedge clk) begin
		hlat_s2 <= hlat_s1;
		rlat_s2 <= rlat_s1;
		dlat_s2 <= dlat_s1;
		lonw_s2 <= lonw[31:0];
	end

	// stage 3: radians
	logic signed [34:0] p1_s3, p2_s3, dp_s3, dl_s3;

	always_ff @(posedge clk) begin
		p1_s3 <= hvt_pkg::to_rad(34'(hlat_s2));
		p2_s3 <= hvt_pkg::to_rad(34'(rlat_s2));
		dp_s3 <= hvt_pkg::to_rad(34'(dlat_s2)) >>> 1;
		dl_s3 <= hvt_pkg::to_rad(34'(lonw_s2)) >>> 1;
	end

	hvt_pkg::cval_t cos_p1, cos_p2, sin_dp, sin_dl;

	hvt_cordic_rot u_rot_p1 (.clk(clk), .angle(p1_s3), .sine(), .cosine(cos_p1));
	hvt_cordic_rot u_rot_p2 (.clk(clk), .angle(p2_s3), .sine(), .cosine(cos_p2));
	hvt_cordic_rot u_rot_dp (.clk(clk), .angle(dp_s3), .sine(sin_dp), .cosine());
	hvt_cordic_rot u_rot_dl (.clk(clk), .angle(dl_s3), .sine(sin_dl), .cosine());

	// stage 4: squares and cosine product
	logic signed [65:0] pr_ss1, pr_cc, pr_ss2;
	hvt_pkg::cval_t     s1sq_s4, c1c2_s4, s2sq_s4;

	assign pr_ss1 = $signed(sin_dp[32:0]) * $signed(sin_dp[32:0]);
	assign pr_cc  = $signed(cos_p1[32:0]) * $signed(cos_p2[32:0]);
	assign pr_ss2 = $signed(sin_dl[32:0]) * $signed(sin_dl[32:0]);

	always_ff @(posedge clk) begin
		s1sq_s4 <= 36'(pr_ss1 >>> 30);
		c1c2_s4 <= 36'(pr_cc >>> 30);
		s2sq_s4 <= 36'(pr_ss2 >>> 30);
	end

	// stage 5: second product
	logic signed [65:0] pr_cs;
	hvt_pkg::cval_t     s1sq_s5, prod_s5;

	assign pr_cs = $signed(c1c2_s4[32:0]) * $signed(s2sq_s4[32:0]);

	always_ff @(posedge clk) begin
		s1sq_s5 <= s1sq_s4;
		prod_s5 <= 36'(pr_cs >>> 30);
	end

	// stage 6: haversine term, clamped
	hvt_pkg::cval_t asum, aclamp, acomp;
	logic [30:0]    a_s6, ac_s6;

	always_comb begin
		asum = s1sq_s5 + prod_s5;
		if (asum[hvt_pkg::CW-1]) begin
			aclamp = '0;
		end else if (asum > hvt_pkg::Q30_ONE) begin
			aclamp = hvt_pkg::Q30_ONE;
		end else begin
			aclamp = asum;
		end
		acomp = hvt_pkg::Q30_ONE - aclamp;
	end

	always_ff @(posedge clk) begin
		a_s6  <= aclamp[30:0];
		ac_s6 <= acomp[30:0];
	end

	logic [30:0] root_a, root_c;

	hvt_isqrt u_sqrt_a (.clk(clk), .rad({a_s6, 30'd0}), .root(root_a));
	hvt_isqrt u_sqrt_c (.clk(clk), .rad({ac_s6, 30'd0}), .root(root_c));

	hvt_pkg::cval_t zang;

	hvt_cordic_vec u_vec (.clk(clk), .xin(root_c), .yin(root_a), .angle(zang));

	// stage 7: central angle times radius
	hvt_pkg::cval_t zc;
	logic [32:0]    twoz;
	logic [55:0]    dist_s7;

	assign zc   = zang[hvt_pkg::CW-1] ? '0 : zang;
	assign twoz = {zc[31:0], 1'b0};

	always_ff @(posedge clk) begin
		dist_s7 <= 56'(twoz) * 56'(radius_q);
	end

	// stage 8: scale to the divider numerator
	logic [61:0]                  scaled;
	logic [hvt_pkg::DIV_BITS-1:0] num_s8;

	assign scaled = 62'(dist_s7[55:8]) * 62'(hvt_pkg::DIST_SCALE);

	always_ff @(posedge clk) begin
		num_s8 <= scaled[61:22];
	end

	logic [hvt_pkg::DIV_BITS-1:0] quo;

	hvt_div u_div (
		.clk (clk),
		.num (num_s8),
		.den (meta_q[hvt_pkg::DIV_IN_STAGE-1].dspeed),
		.quo (quo)
	);

	// result
	hvt_pkg::meta_t mo;
	logic [31:0]    ttc_sel;

	assign mo = meta_q[MD-1];

	always_comb begin
		if (mo.calc) begin
			ttc_sel = (quo[hvt_pkg::DIV_BITS-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
		end else begin
			case (mo.st)
				hvt_pkg::ST_QUAD:   ttc_sel = hvt_pkg::SENT_FAR;
				hvt_pkg::ST_FASTER: ttc_sel = mo.hav ? hvt_pkg::SENT_FAR : hvt_pkg::SENT_SLOW;
				hvt_pkg::ST_EQUAL:  ttc_sel = mo.hav ? hvt_pkg::SENT_SLOW : 32'd0;
				default:            ttc_sel = 32'd0;
			endcase
		end
	end

	logic        done_q;
	logic [31:0] ttc_q;
	logic [1:0]  status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[MD-1];
		end
	end

	always_ff @(posedge clk) begin
		ttc_q    <= ttc_sel;
		status_q <= mo.st;
	end

	assign done   = done_q;
	assign ttc_q8 = ttc_q;
	assign status = status_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(hvt_pkg::OUT_LAT) done)
		else $error("result strobe missing after pipeline latency");

	a_quad_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == hvt_pkg::ST_QUAD) |-> ttc_q8 == hvt_pkg::SENT_FAR)
		else $error("quadrant miss without far sentinel");

	a_faster_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == hvt_pkg::ST_FASTER) |->
		(ttc_q8 == hvt_pkg::SENT_FAR || ttc_q8 == hvt_pkg::SENT_SLOW))
		else $error("faster remote without sentinel");

endmodule
